FILE: design/lphs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the linear probing hash set.
// Depends on nothing; imported by lphs_hash, linear_probe_hash_set and the testbench.
package lphs_pkg;

    localparam int DEF_MAX_ENTRIES = 128;
    localparam int DEF_TABLE_SIZE  = 192;
    localparam int DEF_KEY_BYTES   = 4;

    localparam int KEY_W     = 32;
    localparam int ROT_BITS  = 2;
    localparam int OUT_W     = 16;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
    } slot_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_HASH,
        ST_CHECK,
        ST_CLEAR,
        ST_DONE
    } lphs_state_t;

endpackage

FILE: design/lphs_hash.sv
`timescale 1ns / 1ps
// Home slot unit: byte rotate-xor hash and reduction modulo the table size.
// Three register stages; depends on lphs_pkg.
module lphs_hash
    import lphs_pkg::*;
#(
    parameter int TABLE_SIZE = DEF_TABLE_SIZE,
    parameter int KEY_BYTES  = DEF_KEY_BYTES
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [KEY_W-1:0]              key,
    output logic                          done,
    output logic [$clog2(TABLE_SIZE)-1:0] slot
);

    localparam int SLOT_W = $clog2(TABLE_SIZE);
    localparam int R_W    = SLOT_W + 1;
    localparam logic [KEY_W-1:0] RECIP = KEY_W'((64'd1 << KEY_W) / TABLE_SIZE);
    localparam logic [R_W-1:0]   TSIZE = R_W'(TABLE_SIZE);

    logic [2:0]        vld_reg;
    logic [KEY_W-1:0]  h_comb;
    logic [63:0]       prod;
    logic [KEY_W-1:0]  h1_reg;
    logic [KEY_W-1:0]  q_reg;
    logic [63:0]       qt_full;
    logic [R_W-1:0]    r_reg;
    logic [R_W-1:0]    r_sub;
    logic [SLOT_W-1:0] slot_reg;

    // Fold the key bytes, lowest first; bytes above the key width are zero.
    always_comb begin
        logic [63:0] key_wide;
        key_wide = {32'd0, key};
        h_comb   = {24'd0, key_wide[7:0]};
        for (int i = 1; i < KEY_BYTES; i++) begin
            h_comb = {h_comb[KEY_W-ROT_BITS-1:0], h_comb[KEY_W-1:KEY_W-ROT_BITS]}
                     ^ {24'd0, key_wide[8*i +: 8]};
        end
    end

    // Quotient estimate is at most one short, so the remainder stays below 2x.
    assign prod    = 64'(h_comb) * 64'(RECIP);
    assign qt_full = 64'(q_reg) * 64'(TABLE_SIZE);
    assign r_sub   = r_reg - TSIZE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[1:0], start};
        end
    end

    always_ff @(posedge aclk) begin
        h1_reg   <= h_comb;
        q_reg    <= prod[63:32];
        r_reg    <= h1_reg[R_W-1:0] - qt_full[R_W-1:0];
        slot_reg <= (r_reg >= TSIZE) ? r_sub[SLOT_W-1:0] : r_reg[SLOT_W-1:0];
    end

    assign done = vld_reg[2];
    assign slot = slot_reg;

endmodule

FILE: design/linear_probe_hash_set.sv
`timescale 1ns / 1ps
// Linear probing hash set of 32-bit device keys; depends on lphs_pkg and lphs_hash.
// Lookup/insert: after the home slot pipeline, one slot per cycle is probed through the
//   table read port until a hit, an empty slot or a full lap of the table.
// Lookup at the limit, insert at the limit and the unused code skip probing. Clear sweeps the table.
// Reset: a clearing pass sweeps the table; s_tready stays low
//   until it ends. One transaction at a time; the result register holds while stalled.
module linear_probe_hash_set
    import lphs_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int TABLE_SIZE  = DEF_TABLE_SIZE,
    parameter int KEY_BYTES   = DEF_KEY_BYTES
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [31:0]      s_tdata,   // [31:0] device
    input  logic [1:0]       s_tuser,   // [1:0] func
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // [0] present, [1] stored, [2] full_res,
                                        // [10:3] count, [15:11] zero
);

    localparam int SLOT_W = $clog2(TABLE_SIZE);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SIZE - 1);
    localparam logic [CNT_W-1:0]  MAX_CNT   = CNT_W'(MAX_ENTRIES);

    // Table memory: valid bit and key per slot.
    slot_t mem [TABLE_SIZE];
    slot_t mem_q_reg;
    logic              mem_re;
    logic [SLOT_W-1:0] mem_raddr;
    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    slot_t             mem_wdata;

    lphs_state_t state_reg, state_next;

    logic [1:0]        op_reg, op_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;     // probe slot, also sweep slot
    logic [SLOT_W-1:0] pcnt_reg, pcnt_next;   // slots probed so far, minus one
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              res_present_reg, res_present_next;
    logic              res_stored_reg, res_stored_next;
    logic              m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]  m_data_reg, m_data_next;

    logic              accept;
    logic              full;
    logic              need_probe;
    logic              hash_start;
    logic              hash_done;
    logic [SLOT_W-1:0] hash_slot;
    logic              hit;
    logic              stop;
    logic              last_probe;
    logic              out_free;
    logic [SLOT_W-1:0] idx_inc;
    logic [CNT_W+7:0]  cnt_ext;

    assign accept     = s_tvalid && s_tready;
    assign full       = cnt_reg >= MAX_CNT;
    assign need_probe = ((s_tuser == OP_LOOKUP) || (s_tuser == OP_INSERT)) && !full;
    assign hash_start = accept && need_probe;
    assign hit        = mem_q_reg.valid && (mem_q_reg.key == key_reg);
    assign stop       = !mem_q_reg.valid || hit;
    assign last_probe = (pcnt_reg == LAST_SLOT);
    assign out_free   = !m_valid_reg || m_tready;
    assign idx_inc    = (idx_reg == LAST_SLOT) ? '0 : idx_reg + SLOT_W'(1);
    assign cnt_ext    = {8'd0, cnt_reg};

    lphs_hash #(
        .TABLE_SIZE (TABLE_SIZE),
        .KEY_BYTES  (KEY_BYTES)
    ) u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (hash_start),
        .key     (s_tdata),
        .done    (hash_done),
        .slot    (hash_slot)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT: begin
                if (idx_reg == LAST_SLOT) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == OP_CLEAR)
                        state_next = ST_CLEAR;
                    else if (need_probe)
                        state_next = ST_HASH;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_HASH: begin
                if (hash_done) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (stop || last_probe) state_next = ST_DONE;
            end
            ST_CLEAR: begin
                if (idx_reg == LAST_SLOT) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath, memory controls and handshake outputs.
    always_comb begin
        op_next          = op_reg;
        key_next         = key_reg;
        idx_next         = idx_reg;
        pcnt_next        = pcnt_reg;
        cnt_next         = cnt_reg;
        res_present_next = res_present_reg;
        res_stored_next  = res_stored_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_data_next      = m_data_reg;
        mem_re           = 1'b0;
        mem_raddr        = idx_inc;
        mem_we           = 1'b0;
        mem_waddr        = idx_reg;
        mem_wdata        = '0;
        s_tready         = 1'b0;
        case (state_reg)
            ST_INIT, ST_CLEAR: begin
                // Sweep one slot a cycle, writing it empty.
                mem_we   = 1'b1;
                idx_next = idx_inc;
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (accept) begin
                    op_next          = s_tuser;
                    key_next         = s_tdata;
                    idx_next         = '0;
                    // Lookup at the limit reports present without probing.
                    res_present_next = (s_tuser == OP_LOOKUP) && full;
                    res_stored_next  = 1'b0;
                    if (s_tuser == OP_CLEAR) cnt_next = '0;
                end
            end
            ST_HASH: begin
                if (hash_done) begin
                    mem_re    = 1'b1;
                    mem_raddr = hash_slot;
                    idx_next  = hash_slot;
                    pcnt_next = '0;
                end
            end
            ST_CHECK: begin
                if (stop) begin
                    if (op_reg == OP_LOOKUP) res_present_next = mem_q_reg.valid;
                    if ((op_reg == OP_INSERT) && !mem_q_reg.valid) begin
                        mem_we          = 1'b1;
                        mem_wdata.valid = 1'b1;
                        mem_wdata.key   = key_reg;
                        cnt_next        = cnt_reg + CNT_W'(1);
                        res_stored_next = 1'b1;
                    end
                end else if (!last_probe) begin
                    // Advance to the next slot, wrapping at the table end.
                    mem_re    = 1'b1;
                    idx_next  = idx_inc;
                    pcnt_next = pcnt_reg + SLOT_W'(1);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {5'd0, cnt_ext[7:0], full, res_stored_reg,
                                    res_present_reg};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            idx_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg          <= op_next;
        key_reg         <= key_next;
        pcnt_reg        <= pcnt_next;
        res_present_reg <= res_present_next;
        res_stored_reg  <= res_stored_next;
        m_data_reg      <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge aclk) begin
        if (mem_re) mem_q_reg <= mem[mem_raddr];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Entry count never passes the limit.
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= MAX_CNT)
        else $error("entry count above limit");

    // An insert write bumps the count by exactly one.
    a_ins_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK && mem_we) |=> cnt_reg == $past(cnt_reg) + CNT_W'(1))
        else $error("insert write without count update");

    // Table writes happen only in a sweep or at the end of a probe.
    a_we_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == ST_INIT || state_reg == ST_CLEAR ||
                    state_reg == ST_CHECK))
        else $error("table write outside sweep or probe");

    // The home slot always lies inside the table.
    a_home_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        hash_done |-> hash_slot <= LAST_SLOT)
        else $error("home slot out of range");

    // A result never reports both present and stored.
    a_one_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("present and stored both set");

endmodule

FILE: tb/linear_probe_hash_set_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the linear probing hash set: it drives lookup, insert, clear and
// unused-code transactions and compares every result against a cycle-free table shadow.
// Depends on lphs_pkg and the linear_probe_hash_set RTL.
module linear_probe_hash_set_tb;
    import lphs_pkg::*;

    localparam int MAX_ENTRIES = DEF_MAX_ENTRIES;
    localparam int TABLE_SIZE  = DEF_TABLE_SIZE;
    localparam int KEY_BYTES   = DEF_KEY_BYTES;

    // Operation code the block must treat as a no-op
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Longest single transaction is a clear or a full-table probe
    localparam int DRAIN_CYCLES = 2 * TABLE_SIZE;
    localparam int HOLD_CYCLES  = 300;

    // One expected result, same field order as m_tdata from bit 0 up
    typedef struct packed {
        logic [7:0] count;
        logic       full;
        logic       stored;
        logic       present;
    } set_result_t;

    logic             aclk     = 1'b0;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [31:0]      s_tdata  = '0;   // [31:0] device
    logic [1:0]       s_tuser  = '0;   // [1:0] func
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;         // [0] present, [1] stored, [2] full_res, [10:3] count

    // Shadow copy of the table contents
    logic [31:0] shadow_key   [TABLE_SIZE];
    bit          shadow_valid [TABLE_SIZE];
    int unsigned shadow_count;

    set_result_t expected_results[$];
    logic [31:0] key_pool[$];
    int          error_count   = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          hold_request  = 1'b0;

    linear_probe_hash_set #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .TABLE_SIZE  (TABLE_SIZE),
        .KEY_BYTES   (KEY_BYTES)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #8_000_000;
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Shadow table
    // ------------------------------------------------------------------------

    // Home slot: fold key bytes lowest first, rotate left by 2 before each XOR.
    // Bytes beyond the 32-bit key read as zero.
    function automatic int unsigned home_slot(input logic [31:0] key);
        logic [63:0] wide;
        logic [31:0] h;
        wide = {32'd0, key};
        h    = {24'd0, wide[7:0]};
        for (int i = 1; i < KEY_BYTES && i < 8; i++) begin
            h = {h[29:0], h[31:30]} ^ {24'd0, wide[8*i +: 8]};
        end
        return h % TABLE_SIZE;
    endfunction

    // Walk up from the home slot, wrapping, until the key or an empty slot shows up.
    // Gives up after a full lap of the table.
    function automatic bit probe_table(input logic [31:0] key, output int unsigned slot);
        int unsigned n;
        bit          found;
        slot  = home_slot(key);
        n     = 0;
        found = 1'b0;
        while (!found && n < TABLE_SIZE) begin
            if (!shadow_valid[slot] || shadow_key[slot] == key) begin
                found = 1'b1;
            end else begin
                slot = (slot + 1 == TABLE_SIZE) ? 0 : slot + 1;
                n++;
            end
        end
        return found;
    endfunction

    // Apply one operation to the shadow and return what the block should report
    function automatic set_result_t predict_set_op(input logic [1:0] op,
                                                   input logic [31:0] key);
        set_result_t res;
        int unsigned slot;
        res = '0;
        case (op)
            OP_LOOKUP: begin
                if (shadow_count >= MAX_ENTRIES) begin
                    res.present = 1'b1;
                end else if (probe_table(key, slot) && shadow_valid[slot]) begin
                    res.present = 1'b1;
                end
            end
            OP_INSERT: begin
                if (shadow_count < MAX_ENTRIES && probe_table(key, slot)
                        && !shadow_valid[slot]) begin
                    shadow_key[slot]   = key;
                    shadow_valid[slot] = 1'b1;
                    shadow_count++;
                    res.stored = 1'b1;
                end
            end
            OP_CLEAR: begin
                foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
                shadow_count = 0;
            end
            default: begin
            end
        endcase
        res.full  = (shadow_count >= MAX_ENTRIES);
        res.count = shadow_count[7:0];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus side
    // ------------------------------------------------------------------------

    // Offer one transaction, with a random gap in front of it. tvalid is left high on
    // return so back-to-back transactions never drop and re-raise it in one step.
    task automatic send_op(input logic [1:0] op, input logic [31:0] key);
        set_result_t exp_res;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            s_tuser  <= 2'($urandom_range(3));
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= key;
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        exp_res = predict_set_op(op, key);
        expected_results.push_back(exp_res);
    endtask

    // Pause the sender until every outstanding result has come back, then let the
    // block settle for its longest transaction.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [31:0] key_with_home(input int unsigned target);
        logic [31:0] k;
        do k = $urandom; while (home_slot(k) != target);
        return k;
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: random backpressure, plus a long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES;
            end
            if (stall_left != 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: compare each accepted result with the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        set_result_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result transaction, m_tdata=%h", m_tdata);
                error_count++;
            end else begin
                exp_res = expected_results.pop_front();
                if (m_tdata[0] !== exp_res.present) begin
                    $error("present: expected %0d, actual %0d", exp_res.present, m_tdata[0]);
                    error_count++;
                end
                if (m_tdata[1] !== exp_res.stored) begin
                    $error("stored: expected %0d, actual %0d", exp_res.stored, m_tdata[1]);
                    error_count++;
                end
                if (m_tdata[2] !== exp_res.full) begin
                    $error("full_res: expected %0d, actual %0d", exp_res.full, m_tdata[2]);
                    error_count++;
                end
                if (m_tdata[10:3] !== exp_res.count) begin
                    $error("count: expected %0d, actual %0d", exp_res.count, m_tdata[10:3]);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Empty table, key extremes, duplicate insert, unused code, clear
    task automatic test_basic_ops();
        send_idle_pct = 34;
        recv_idle_pct = 71;
        send_op(OP_LOOKUP, 32'h0000_0000);
        send_op(OP_LOOKUP, 32'hFFFF_FFFF);
        send_op(OP_INSERT, 32'h0000_0000);
        send_op(OP_INSERT, 32'hFFFF_FFFF);
        send_op(OP_INSERT, 32'h0000_0000);     // already stored: no change
        send_op(OP_LOOKUP, 32'h0000_0000);
        send_op(OP_LOOKUP, 32'hFFFF_FFFF);
        send_op(OP_LOOKUP, 32'h8000_0001);
        send_op(OP_UNUSED, 32'hA5A5_5A5A);     // reports only the count and full flag
        send_op(OP_INSERT, 32'hA5A5_5A5A);
        send_op(OP_CLEAR,  32'hFFFF_FFFF);
        send_op(OP_LOOKUP, 32'hFFFF_FFFF);     // gone after clear
        send_op(OP_UNUSED, 32'h0000_0000);
        wait_for_results();
    endtask

    // Build a collision chain on the last slot so probing wraps to slot 0 and beyond
    task automatic test_probe_wrap();
        logic [31:0] chain[4];
        logic [31:0] low_key;
        foreach (chain[i]) chain[i] = key_with_home(TABLE_SIZE - 1);
        low_key = key_with_home(0);
        send_op(OP_INSERT, chain[0]);          // lands on the last slot
        send_op(OP_INSERT, chain[1]);          // wraps to slot 0
        send_op(OP_INSERT, chain[2]);          // slot 1
        send_op(OP_INSERT, low_key);           // home 0 is taken, goes to slot 2
        send_op(OP_LOOKUP, chain[2]);
        send_op(OP_LOOKUP, low_key);
        send_op(OP_LOOKUP, chain[3]);          // walks the whole chain to an empty slot
        send_op(OP_INSERT, chain[1]);          // duplicate deep in the chain
        send_op(OP_CLEAR,  32'h0);
        send_op(OP_LOOKUP, chain[0]);
        wait_for_results();
    endtask

    // Fill to the entry limit with a long receiver hold-off partway through, then hit the limit
    task automatic test_fill_to_limit();
        logic [31:0] k;
        int          n;
        send_op(OP_CLEAR, $urandom);
        key_pool.delete();
        n = 0;
        while (shadow_count < MAX_ENTRIES) begin
            if (n % 10 == 9 && key_pool.size() != 0) begin
                k = key_pool[$urandom_range(key_pool.size() - 1)];
            end else begin
                k = $urandom;
            end
            if (n == 40) hold_request = 1'b1;   // keep offering while the output is stuck
            send_op(OP_INSERT, k);
            key_pool.push_back(k);
            n++;
        end
        send_op(OP_INSERT, $urandom);          // at the limit: nothing stored
        send_op(OP_INSERT, key_pool[0]);
        send_op(OP_LOOKUP, $urandom);          // absent key still reads as present
        send_op(OP_LOOKUP, key_pool[5]);
        send_op(OP_UNUSED, $urandom);
        send_op(OP_CLEAR,  $urandom);
        send_op(OP_LOOKUP, key_pool[5]);
        key_pool.delete();
        wait_for_results();
    endtask

    // Weighted random mix; clears are rare until the table fills, so it keeps
    // cycling through near-full and full states
    task automatic test_random_mix(input int n_items, input int snd_pct, input int rcv_pct);
        int          r;
        int          clear_thr;
        int          reuse_pct;
        logic [1:0]  op;
        logic [31:0] k;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        for (int i = 0; i < n_items; i++) begin
            r         = $urandom_range(999);
            clear_thr = (shadow_count >= MAX_ENTRIES) ? 40 : 3;
            if (r < clear_thr)           op = OP_CLEAR;
            else if (r < clear_thr + 30) op = OP_UNUSED;
            else if (r < 560)            op = OP_INSERT;
            else                         op = OP_LOOKUP;
            reuse_pct = (op == OP_INSERT) ? 20 : 50;
            if (key_pool.size() != 0 && $urandom_range(99) < reuse_pct) begin
                k = key_pool[$urandom_range(key_pool.size() - 1)];
            end else begin
                k = $urandom;
            end
            send_op(op, k);
            if (op == OP_INSERT) key_pool.push_back(k);
            if (op == OP_CLEAR) key_pool.delete();
        end
        wait_for_results();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
        shadow_count = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        test_basic_ops();
        test_probe_wrap();
        test_fill_to_limit();
        test_random_mix(300, 34, 71);
        test_random_mix(300, 71, 34);
        test_random_mix(300, 0, 0);

        if (error_count == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/lphs_pkg.sv
design/lphs_hash.sv
design/linear_probe_hash_set.sv
tb/linear_probe_hash_set_tb.sv
